[rtl/core/morph_target_vertex_blend_assert.svh]
// assertion macros shared by the blend rtl
`ifndef MORPH_TARGET_VERTEX_BLEND_ASSERT_SVH
`define MORPH_TARGET_VERTEX_BLEND_ASSERT_SVH

// consequent must hold in the same cycle
`define MTVB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the next cycle
`define MTVB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/mtvb_pkg.sv]
package mtvb_pkg;

   localparam int WEIGHT_REGS = 4;
   localparam int WIDX_W      = $clog2(WEIGHT_REGS);
   localparam int WEIGHT_W    = 16;
   localparam int CSR_IDX_W   = 3;

   localparam int POS_ACC_W = 52;
   localparam int NRM_ACC_W = 34;
   localparam int MAG_W     = 35;
   localparam int NORM_W    = 25;
   localparam int SUMSQ_W   = 52;
   localparam int ROOT_W    = 26;
   localparam int NUM_W     = 40;
   localparam int QUO_W     = 15;
   localparam int MUL_A_W   = 33;
   localparam int MUL_B_W   = 26;
   localparam int PROD_W    = 59;

   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_ONE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_TWO   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_THREE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_FOUR  = 3'd3;

   typedef struct packed {
      logic [2:0]          slot;
      logic signed [31:0]  pos_x;
      logic signed [31:0]  pos_y;
      logic signed [31:0]  pos_z;
      logic signed [15:0]  nrm_x;
      logic signed [15:0]  nrm_y;
      logic signed [15:0]  nrm_z;
   } mtvb_req_type;

   typedef struct packed {
      logic signed [31:0]  out_pos_x;
      logic signed [31:0]  out_pos_y;
      logic signed [31:0]  out_pos_z;
      logic signed [15:0]  out_nrm_x;
      logic signed [15:0]  out_nrm_y;
      logic signed [15:0]  out_nrm_z;
   } mtvb_rsp_type;

endpackage

[rtl/core/mtvb_mul.sv]
module mtvb_mul import mtvb_pkg::*; (
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] mul_a,
   input  logic signed [MUL_B_W-1:0] mul_b,
   output logic signed [PROD_W-1:0]  prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
   end

endmodule

[rtl/core/mtvb_sqrt.sv]
module mtvb_sqrt import mtvb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SUMSQ_W-1:0] radicand,
   output logic               done,
   output logic [ROOT_W-1:0]  root
);

   logic [SUMSQ_W-1:0] rem_ff;
   logic [SUMSQ_W:0]   res_ff;
   logic [SUMSQ_W-1:0] bit_ff;
   logic               run_ff;
   logic               done_ff;
   logic [SUMSQ_W:0]   trial;

   assign trial = res_ff + (SUMSQ_W+1)'(bit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && bit_ff[0]) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // digit-by-digit root, two radicand bits a cycle
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= radicand;
         res_ff <= '0;
         bit_ff <= SUMSQ_W'(1) << (SUMSQ_W - 2);
      end else if (run_ff) begin
         if ((SUMSQ_W+1)'(rem_ff) >= trial) begin
            rem_ff <= rem_ff - trial[SUMSQ_W-1:0];
            res_ff <= (res_ff >> 1) + (SUMSQ_W+1)'(bit_ff);
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule

[rtl/core/mtvb_div.sv]
module mtvb_div import mtvb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  numer,
   input  logic [ROOT_W-1:0] denom,
   output logic              done,
   output logic [QUO_W-1:0]  quot
);

   logic [NUM_W-1:0] rem_ff;
   logic [NUM_W-1:0] den_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [3:0]       cnt_ff;
   logic             run_ff;
   logic             done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == 4'd0) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // restoring division, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= numer;
         den_ff <= NUM_W'(denom) << (QUO_W - 1);
         quo_ff <= '0;
         cnt_ff <= 4'(QUO_W - 1);
      end else if (run_ff) begin
         if (rem_ff >= den_ff) begin
            rem_ff <= rem_ff - den_ff;
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
         end
         den_ff <= den_ff >> 1;
         cnt_ff <= cnt_ff - 4'd1;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

[rtl/core/morph_target_vertex_blend.sv]
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  mtvb_req_type
// rsp       out        rsp_valid / rsp_stall  mtvb_rsp_type
// csr       in         csr_valid / csr_ready  csr_index, csr_wdata
//
// a base record is taken while idle, a target record issues six products on the shared multiplier
// the last target then runs up to 24 shift steps, 3 squares, a 26-step root
// and three 15-step divides, all through the one sequencer
// reset is synchronous and clears weights, base and accumulators
// the result waits in an output register, so the next vertex is taken while rsp is stalled
module morph_target_vertex_blend import mtvb_pkg::*; #(
   parameter int NUM_TARGETS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mtvb_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mtvb_rsp_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [WEIGHT_W-1:0]   csr_wdata
);

   `include "morph_target_vertex_blend_assert.svh"

   localparam logic [3:0] LAST_SLOT = 4'(NUM_TARGETS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_PREP  = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_SQ    = 3'd4;
   localparam logic [2:0] S_SQRT  = 3'd5;
   localparam logic [2:0] S_DIV   = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   function automatic logic [1:0] comp_of(input logic [2:0] v);
      logic [2:0] d;
      begin
         d = v - 3'd3;
         if (v < 3'd3) begin
            comp_of = v[1:0];
         end else if (v < 3'd6) begin
            comp_of = d[1:0];
         end else begin
            comp_of = 2'd0;
         end
      end
   endfunction

   logic [2:0]                 state_ff;
   logic [2:0]                 state_in;
   logic [WEIGHT_W-1:0]        weight_ff [WEIGHT_REGS];
   logic signed [31:0]         base_pos_ff [3];
   logic signed [15:0]         base_nrm_ff [3];
   logic signed [POS_ACC_W-1:0] pos_acc_ff [3];
   logic signed [NRM_ACC_W-1:0] nrm_acc_ff [3];
   logic signed [31:0]         in_pos_ff [3];
   logic signed [15:0]         in_nrm_ff [3];
   logic [WEIGHT_W-1:0]        w_ff;
   logic                       last_ff;
   logic [2:0]                 idx_ff;
   logic [MAG_W-1:0]           mag_ff [3];
   logic                       neg_ff [3];
   logic [SUMSQ_W-1:0]         sumsq_ff;
   logic signed [31:0]         res_pos_ff [3];
   logic signed [15:0]         res_nrm_ff [3];
   logic                       rsp_valid_ff;
   mtvb_rsp_type               rsp_data_ff;

   logic                       req_fire;
   logic [2:0]                 slot_m1;
   logic [WEIGHT_W-1:0]        w_sel;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   mul_prod;
   logic [1:0]                 issue_sel;
   logic [1:0]                 acc_sel;
   logic [2:0]                 idx_m1;
   logic                       any_hi;
   logic                       all_lo;
   logic                       all_zero;
   logic                       sqrt_start;
   logic                       sqrt_done;
   logic [ROOT_W-1:0]          sqrt_root;
   logic                       div_start;
   logic                       div_done;
   logic [QUO_W-1:0]           div_q;
   logic [1:0]                 div_sel;
   logic [NUM_W-1:0]           div_num;
   logic                       out_load;

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign slot_m1 = req_data.slot - 3'd1;
   assign w_sel   = (slot_m1 < 3'(WEIGHT_REGS)) ? weight_ff[slot_m1[WIDX_W-1:0]] : '0;

   assign idx_m1    = idx_ff - 3'd1;
   assign issue_sel = comp_of(idx_ff);
   assign acc_sel   = comp_of(idx_m1);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_SQ) begin
         mul_a = MUL_A_W'(mag_ff[issue_sel][NORM_W-1:0]);
         mul_b = MUL_B_W'(mag_ff[issue_sel][NORM_W-1:0]);
      end else if (idx_ff < 3'd3) begin
         mul_a = MUL_A_W'(in_pos_ff[issue_sel]) - MUL_A_W'(base_pos_ff[issue_sel]);
         mul_b = MUL_B_W'(w_ff);
      end else begin
         mul_a = MUL_A_W'(in_nrm_ff[issue_sel]) - MUL_A_W'(base_nrm_ff[issue_sel]);
         mul_b = MUL_B_W'(w_ff);
      end
   end

   always_comb begin
      any_hi   = 1'b0;
      all_lo   = 1'b1;
      all_zero = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (mag_ff[i][MAG_W-1:NORM_W] != '0) any_hi = 1'b1;
         if (mag_ff[i][MAG_W-1:NORM_W-1] != '0) all_lo = 1'b0;
         if (mag_ff[i] != '0) all_zero = 1'b0;
      end
   end

   assign sqrt_start = (state_ff == S_SQ) && (idx_ff == 3'd4);
   assign div_start  = ((state_ff == S_SQRT) && sqrt_done) ||
                       ((state_ff == S_DIV) && div_done && idx_ff != 3'd2);
   assign div_sel    = (state_ff == S_SQRT) ? 2'd0 : idx_ff[1:0] + 2'd1;
   assign div_num    = NUM_W'({mag_ff[div_sel][NORM_W-1:0], 14'b0}) +
                       NUM_W'(sqrt_root[ROOT_W-1:1]);
   assign out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   mtvb_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (mul_prod)
   );

   mtvb_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sumsq_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   mtvb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (sqrt_root),
      .done  (div_done),
      .quot  (div_q)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_data.slot != 3'd0 && {1'b0, req_data.slot} <= LAST_SLOT) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (idx_ff == 3'd6) state_in = last_ff ? S_PREP : S_IDLE;
         end
         S_PREP:  state_in = S_SHIFT;
         S_SHIFT: begin
            if (all_zero) begin
               state_in = S_OUT;
            end else if (!any_hi && !all_lo) begin
               state_in = S_SQ;
            end
         end
         S_SQ:    if (idx_ff == 3'd4) state_in = S_SQRT;
         S_SQRT:  if (sqrt_done) state_in = S_DIV;
         S_DIV:   if (div_done && idx_ff == 3'd2) state_in = S_OUT;
         S_OUT:   if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WEIGHT_REGS; i++) weight_ff[i] <= '0;
         for (int i = 0; i < 3; i++) begin
            base_pos_ff[i] <= '0;
            base_nrm_ff[i] <= '0;
            pos_acc_ff[i]  <= '0;
            nrm_acc_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready && csr_index < 3'(WEIGHT_REGS)) begin
            weight_ff[csr_index[WIDX_W-1:0]] <= csr_wdata;
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (req_fire && req_data.slot == 3'd0) begin
            base_pos_ff[0] <= req_data.pos_x;
            base_pos_ff[1] <= req_data.pos_y;
            base_pos_ff[2] <= req_data.pos_z;
            base_nrm_ff[0] <= req_data.nrm_x;
            base_nrm_ff[1] <= req_data.nrm_y;
            base_nrm_ff[2] <= req_data.nrm_z;
            for (int i = 0; i < 3; i++) begin
               pos_acc_ff[i] <= '0;
               nrm_acc_ff[i] <= '0;
            end
         end

         // product of the previous issue lands in the cycle after it
         if (state_ff == S_MUL && idx_ff != 3'd0) begin
            if (idx_m1 < 3'd3) begin
               pos_acc_ff[acc_sel] <= pos_acc_ff[acc_sel] + mul_prod[POS_ACC_W-1:0];
            end else begin
               nrm_acc_ff[acc_sel] <= nrm_acc_ff[acc_sel] + mul_prod[NRM_ACC_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      logic signed [POS_ACC_W:0] t;
      logic signed [39:0]        p;
      logic signed [35:0]        n;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               in_pos_ff[0] <= req_data.pos_x;
               in_pos_ff[1] <= req_data.pos_y;
               in_pos_ff[2] <= req_data.pos_z;
               in_nrm_ff[0] <= req_data.nrm_x;
               in_nrm_ff[1] <= req_data.nrm_y;
               in_nrm_ff[2] <= req_data.nrm_z;
               w_ff         <= w_sel;
               last_ff      <= ({1'b0, req_data.slot} == LAST_SLOT);
               idx_ff       <= 3'd0;
            end
         end
         S_MUL: idx_ff <= idx_ff + 3'd1;
         S_PREP: begin
            for (int i = 0; i < 3; i++) begin
               t = (POS_ACC_W+1)'(pos_acc_ff[i]) + (POS_ACC_W+1)'(16384);
               p = 40'(base_pos_ff[i]) + 40'($signed(t[POS_ACC_W:15]));
               if (p[39:31] != {9{p[39]}}) begin
                  res_pos_ff[i] <= p[39] ? 32'sh8000_0000 : 32'sh7fff_ffff;
               end else begin
                  res_pos_ff[i] <= p[31:0];
               end
               n = (36'(base_nrm_ff[i]) <<< 15) + 36'(nrm_acc_ff[i]);
               neg_ff[i] <= n[35];
               mag_ff[i] <= n[35] ? MAG_W'(-n) : MAG_W'(n);
            end
         end
         S_SHIFT: begin
            idx_ff   <= 3'd0;
            sumsq_ff <= '0;
            for (int i = 0; i < 3; i++) begin
               if (all_zero) begin
                  res_nrm_ff[i] <= '0;
               end else if (any_hi) begin
                  mag_ff[i] <= mag_ff[i] >> 1;
               end else if (all_lo) begin
                  mag_ff[i] <= mag_ff[i] << 1;
               end
            end
         end
         S_SQ: begin
            idx_ff <= idx_ff + 3'd1;
            if (idx_ff != 3'd0 && idx_ff != 3'd4) begin
               sumsq_ff <= sumsq_ff + mul_prod[SUMSQ_W-1:0];
            end
         end
         S_SQRT: idx_ff <= 3'd0;
         S_DIV: begin
            if (div_done) begin
               res_nrm_ff[idx_ff[1:0]] <= neg_ff[idx_ff[1:0]] ? -16'(div_q) : 16'(div_q);
               idx_ff <= idx_ff + 3'd1;
            end
         end
         S_OUT: begin
            if (out_load) begin
               rsp_data_ff.out_pos_x <= res_pos_ff[0];
               rsp_data_ff.out_pos_y <= res_pos_ff[1];
               rsp_data_ff.out_pos_z <= res_pos_ff[2];
               rsp_data_ff.out_nrm_x <= res_nrm_ff[0];
               rsp_data_ff.out_nrm_y <= res_nrm_ff[1];
               rsp_data_ff.out_nrm_z <= res_nrm_ff[2];
            end
         end
         default: idx_ff <= 3'd0;
      endcase
   end

   `MTVB_ASSERT_NEXT(a_out_loads, (state_ff == S_OUT) && !rsp_valid_ff, rsp_valid_ff, "result not loaded")
   `MTVB_ASSERT_NOW(a_root_range, sqrt_done, sqrt_root[ROOT_W-1:ROOT_W-2] != 2'b00, "root below range")
   `MTVB_ASSERT_NOW(a_quot_range, div_done, div_q <= 15'd16384, "normal component above one")
   `MTVB_ASSERT_NEXT(a_base_idle, req_fire && req_data.slot == 3'd0, state_ff == S_IDLE, "base record left idle")

endmodule
